FILE: design/ppgpd_pkg.sv
// Shared types and constants for the PPG adaptive peak detector.
`default_nettype none
package ppgpd_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAND,
    ST_CONF,
    ST_EMA,
    ST_THR,
    ST_MED,
    ST_MFIN,
    ST_MISS,
    ST_PUSH0,
    ST_PUSH1
  } state_e;

  typedef struct packed {
    logic cap_in;
    logic cand;
    logic conf;
    logic ema;
    logic thr;
    logic med_step;
    logic med_fin;
    logic miss;
    logic push0;
    logic push1;
  } cmd_t;

  typedef struct packed {
    logic       ring_wr;
    logic       med_last;
    logic [1:0] n_res;
    logic       fifo_room;
  } sts_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IV_W       = 12;
  localparam int IDX_W      = 32;
  localparam int RATIO_W    = 8;
  localparam int MOT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THR_FACTOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_IV       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IV       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_LIMIT = 3'd5;

  localparam int THR_FACTOR_RESET = 102;
  localparam int MIN_IV_RESET     = 30;
  localparam int MAX_IV_RESET     = 200;
  localparam int OUT_LOW_RESET    = 32;
  localparam int OUT_HIGH_RESET   = 96;
  localparam int MOT_LIMIT_RESET  = 4915;

  localparam int THRESH_FLOOR     = 164;
  localparam int HALF_Q14         = 8192;
  localparam int EMA_SHIFT        = 3;
  localparam int MEDIAN_MIN_COUNT = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

endpackage
`default_nettype wire

FILE: design/ppgpd_ctrl.sv
// Sequencing state machine of the PPG adaptive peak detector.
`default_nettype none
module ppgpd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ppgpd_pkg::sts_t sts_i,
  output ppgpd_pkg::cmd_t      cmd_o
);
  import ppgpd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.fifo_room) state_d = ST_CAND;
      end
      ST_CAND:  state_d = ST_CONF;
      ST_CONF:  state_d = ST_EMA;
      ST_EMA:   state_d = ST_THR;
      ST_THR:   state_d = sts_i.ring_wr ? ST_MED : ST_MISS;
      ST_MED: begin
        if (sts_i.med_last) state_d = ST_MFIN;
      end
      ST_MFIN:  state_d = ST_MISS;
      ST_MISS:  state_d = ST_PUSH0;
      ST_PUSH0: state_d = (sts_i.n_res == 2'd2) ? ST_PUSH1 : ST_IDLE;
      ST_PUSH1: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = sts_i.fifo_room;
        cmd_o.cap_in = in_valid_i && sts_i.fifo_room;
      end
      ST_CAND:  cmd_o.cand     = 1'b1;
      ST_CONF:  cmd_o.conf     = 1'b1;
      ST_EMA:   cmd_o.ema      = 1'b1;
      ST_THR:   cmd_o.thr      = 1'b1;
      ST_MED:   cmd_o.med_step = 1'b1;
      ST_MFIN:  cmd_o.med_fin  = 1'b1;
      ST_MISS:  cmd_o.miss     = 1'b1;
      ST_PUSH0: cmd_o.push0    = (sts_i.n_res != 2'd0);
      ST_PUSH1: cmd_o.push1    = 1'b1;
      default: begin
      end
    endcase
  end

  a_cand_then_conf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CAND |=> state_q == ST_CONF)
    else $error("candidate step not followed by confirmation step");

  a_med_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MED |=> state_q == ST_MED || state_q == ST_MFIN)
    else $error("median scan left early");

  a_push1_after_push0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push1 |-> $past(cmd_o.push0))
    else $error("second result pushed without first");

endmodule
`default_nettype wire

FILE: design/ppgpd_dp.sv
// Datapath of the PPG adaptive peak detector: state, interval ring, median scan, result queue.
`default_nettype none
module ppgpd_dp #(
  parameter int HISTORY_DEPTH = 8,
  parameter int SAMPLE_BITS   = 16,
  parameter int INTERVAL_BITS = 12
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire ppgpd_pkg::cmd_t                       cmd_i,
  output ppgpd_pkg::sts_t                            sts_o,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  wire logic [ppgpd_pkg::MOT_W-1:0]           motion_i,
  input  wire logic                                  motion_present_i,
  input  wire logic                                  buffer_end_i,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [ppgpd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [ppgpd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [ppgpd_pkg::IDX_W-1:0]                peak_index_o,
  output logic signed [SAMPLE_BITS-1:0]              amplitude_o,
  output logic [ppgpd_pkg::IV_W-1:0]                 interval_o,
  output logic                                       flag_outlier_o,
  output logic                                       flag_motion_o,
  output logic                                       flag_interpolated_o,
  output logic [ppgpd_pkg::IV_W-1:0]                 median_interval_o,
  output logic                                       last_of_run_o
);
  import ppgpd_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int HD     = HISTORY_DEPTH;
  localparam int PTR_W  = $clog2(HD);
  localparam int FILL_W = $clog2(HD + 1);
  localparam int MED_W  = INTERVAL_BITS + 1;
  localparam int RES_W  = IDX_W + SB + IV_W + 3;
  localparam int ENT_W  = RES_W + IV_W + 1;
  localparam logic signed [SB-1:0] HALF_VAL  = SB'(HALF_Q14);
  localparam logic signed [SB-1:0] THR_RST   = SB'((THR_FACTOR_RESET * HALF_Q14) >> 8);
  localparam logic signed [SB-1:0] MAX_POS   = SB'((1 << (SB - 1)) - 1);
  localparam logic signed [SB+9:0] FLOOR_EXT = (SB+10)'(THRESH_FLOOR);
  localparam logic signed [SB+9:0] MAX_EXT   = (SB+10)'((1 << (SB - 1)) - 1);

  function automatic logic signed [SB-1:0] ema_f(input logic signed [SB-1:0] m,
                                                 input logic signed [SB-1:0] x);
    logic signed [SB:0] d;
    d = $signed({x[SB-1], x}) - $signed({m[SB-1], m});
    return m + SB'(d >>> EMA_SHIFT);
  endfunction

  logic [RATIO_W-1:0] thr_factor_q, out_low_q, out_high_q;
  logic [IV_W-1:0]    min_iv_q, max_iv_q;
  logic [MOT_W-1:0]   mot_limit_q;

  logic signed [SB-1:0] x_q, last_x_q, cand_amp_q, peak_mean_q, trough_q, thr_q;
  logic signed [SB:0]   prev_slope_q;
  logic [MOT_W-1:0]     mot_now_q, prev_motion_q, cand_mot_q;
  logic                 bend_q, have_prev_q, cand_held_q, have_last_q, ring_wr_q;
  logic [IDX_W-1:0]     cand_at_q, last_q, cnt_q;
  logic [INTERVAL_BITS-1:0] ring_q [HD];
  logic [PTR_W-1:0]     wpos_q, med_i_q;
  logic [FILL_W-1:0]    fill_q;
  logic [MED_W-1:0]     med2_q;
  logic [INTERVAL_BITS-1:0] lo_q, hi_q;
  logic [1:0]           nres_q;
  logic [RES_W-1:0]     res_q [2];
  logic [ENT_W-1:0]     fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] fcnt_q;

  logic signed [SB:0]   slope;
  logic                 turn, take, close, confirm, bad_iv, outlier, miss_hit;
  logic [IDX_W-1:0]     peak_gap, iv, elapsed, miss_at;
  logic [31:0]          prod_hi, prod_lo, iv_x128;
  logic [38:0]          elapsed_x128;
  logic signed [SB:0]   diff_pt;
  logic signed [SB+9:0] prod_thr, q_thr;
  logic [INTERVAL_BITS-1:0] t_i;
  logic [FILL_W-1:0]    rank, half;
  logic [INTERVAL_BITS-1:0] med;
  logic                 push, pop;
  logic [ENT_W-1:0]     push_ent, head;

  assign slope = have_prev_q ? ($signed({x_q[SB-1], x_q}) -
                                $signed({last_x_q[SB-1], last_x_q})) : '0;
  assign turn  = have_prev_q && (prev_slope_q > 0) && (slope <= 0);
  assign peak_gap = cnt_q - IDX_W'(1) - last_q;
  assign close = have_last_q && (peak_gap < {{(IDX_W-IV_W){1'b0}}, min_iv_q});
  assign take  = !close && (!cand_held_q || (last_x_q > cand_amp_q));

  assign confirm = cand_held_q && (x_q < trough_q) && (slope < 0);
  assign iv      = have_last_q ? (cand_at_q - last_q) : '0;
  assign bad_iv  = have_last_q && ((iv < {{(IDX_W-IV_W){1'b0}}, min_iv_q}) ||
                                   (iv > {{(IDX_W-IV_W){1'b0}}, max_iv_q}));
  assign prod_hi = {{(32-MED_W){1'b0}}, med2_q} * {{(32-RATIO_W){1'b0}}, out_high_q};
  assign prod_lo = {{(32-MED_W){1'b0}}, med2_q} * {{(32-RATIO_W){1'b0}}, out_low_q};
  assign iv_x128 = {13'd0, iv[IV_W-1:0], 7'd0};
  assign outlier = have_last_q && (med2_q >= MED_W'(2)) &&
                   ((iv_x128 > prod_hi) || (iv_x128 < prod_lo));

  assign diff_pt  = $signed({peak_mean_q[SB-1], peak_mean_q}) -
                    $signed({trough_q[SB-1], trough_q});
  assign prod_thr = $signed({1'b0, thr_factor_q}) * diff_pt;
  assign q_thr    = prod_thr >>> 8;

  assign elapsed      = cnt_q + IDX_W'(1) - last_q;
  assign elapsed_x128 = {elapsed, 7'd0};
  assign med          = med2_q[MED_W-1:1];
  assign miss_at      = last_q + IDX_W'(med);
  assign miss_hit     = bend_q && have_last_q && (med2_q >= MED_W'(2)) &&
                        (elapsed_x128 > {7'd0, prod_hi}) &&
                        ({{(IDX_W-INTERVAL_BITS){1'b0}}, med} < elapsed);

  assign t_i  = ring_q[med_i_q];
  assign half = fill_q >> 1;
  always_comb begin
    rank = '0;
    for (int j = 0; j < HD; j++) begin
      if ((FILL_W'(j) < fill_q) &&
          ((ring_q[j] < t_i) || ((ring_q[j] == t_i) && (PTR_W'(j) < med_i_q)))) begin
        rank = rank + FILL_W'(1);
      end
    end
  end

  assign push     = cmd_i.push0 || cmd_i.push1;
  assign push_ent = cmd_i.push1 ? {res_q[1], IV_W'(med2_q >> 1), 1'b1}
                                : {res_q[0], IV_W'(med2_q >> 1), (nres_q == 2'd1)};
  assign pop      = out_valid_o && out_ready_i;
  assign head     = fifo_q[rd_q];

  assign out_valid_o = (fcnt_q != '0);
  assign {peak_index_o, amplitude_o, interval_o, flag_outlier_o, flag_motion_o,
          flag_interpolated_o, median_interval_o, last_of_run_o} = head;
  assign cfg_ready_o = 1'b1;

  assign sts_o.ring_wr   = ring_wr_q;
  assign sts_o.med_last  = (med_i_q == PTR_W'(HD - 1));
  assign sts_o.n_res     = nres_q;
  assign sts_o.fifo_room = (fcnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (cmd_i.conf && confirm && !bad_iv && (iv != '0)) begin
      ring_q[wpos_q] <= iv[INTERVAL_BITS-1:0];
    end
    if (cmd_i.conf && confirm && !bad_iv) begin
      res_q[0] <= {cand_at_q, cand_amp_q, iv[IV_W-1:0], outlier,
                   (cand_mot_q > mot_limit_q), 1'b0};
    end
    if (cmd_i.miss && miss_hit) begin
      res_q[nres_q[0]] <= {miss_at, SB'(0), IV_W'(med), 1'b0, 1'b0, 1'b1};
    end
    if (push) begin
      fifo_q[wr_q] <= push_ent;
    end
    if (cmd_i.cap_in) begin
      x_q       <= sample_i;
      mot_now_q <= motion_present_i ? motion_i : prev_motion_q;
      bend_q    <= buffer_end_i;
    end
    if (cmd_i.med_step && (FILL_W'(med_i_q) < fill_q)) begin
      if (rank == half) hi_q <= t_i;
      if (rank == half - FILL_W'(1)) lo_q <= t_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_factor_q  <= RATIO_W'(THR_FACTOR_RESET);
      min_iv_q      <= IV_W'(MIN_IV_RESET);
      max_iv_q      <= IV_W'(MAX_IV_RESET);
      out_low_q     <= RATIO_W'(OUT_LOW_RESET);
      out_high_q    <= RATIO_W'(OUT_HIGH_RESET);
      mot_limit_q   <= MOT_W'(MOT_LIMIT_RESET);
      last_x_q      <= '0;
      prev_slope_q  <= '0;
      prev_motion_q <= '0;
      have_prev_q   <= 1'b0;
      cand_amp_q    <= '0;
      cand_at_q     <= '0;
      cand_mot_q    <= '0;
      cand_held_q   <= 1'b0;
      last_q        <= '0;
      have_last_q   <= 1'b0;
      peak_mean_q   <= HALF_VAL;
      trough_q      <= '0;
      thr_q         <= THR_RST;
      wpos_q        <= '0;
      fill_q        <= '0;
      cnt_q         <= '0;
      med2_q        <= '0;
      med_i_q       <= '0;
      ring_wr_q     <= 1'b0;
      nres_q        <= '0;
      wr_q          <= '0;
      rd_q          <= '0;
      fcnt_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_THR_FACTOR:   thr_factor_q <= cfg_data_i[RATIO_W-1:0];
          REG_MIN_IV:       min_iv_q     <= cfg_data_i[IV_W-1:0];
          REG_MAX_IV:       max_iv_q     <= cfg_data_i[IV_W-1:0];
          REG_OUT_LOW:      out_low_q    <= cfg_data_i[RATIO_W-1:0];
          REG_OUT_HIGH:     out_high_q   <= cfg_data_i[RATIO_W-1:0];
          REG_MOTION_LIMIT: mot_limit_q  <= cfg_data_i[MOT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.cap_in) begin
        nres_q    <= '0;
        ring_wr_q <= 1'b0;
        med_i_q   <= '0;
      end
      if (cmd_i.cand && turn) begin
        if (last_x_q > thr_q) begin
          if (take) begin
            cand_amp_q  <= last_x_q;
            cand_at_q   <= cnt_q - IDX_W'(1);
            cand_mot_q  <= prev_motion_q;
            cand_held_q <= 1'b1;
          end
        end else begin
          trough_q <= ema_f(trough_q, last_x_q);
        end
      end
      if (cmd_i.conf && confirm) begin
        last_q      <= cand_at_q;
        cand_held_q <= 1'b0;
        if (!bad_iv) begin
          have_last_q <= 1'b1;
          nres_q      <= 2'd1;
          if (iv != '0) begin
            ring_wr_q <= 1'b1;
            wpos_q    <= (wpos_q == PTR_W'(HD - 1)) ? '0 : wpos_q + PTR_W'(1);
            if (fill_q != FILL_W'(HD)) fill_q <= fill_q + FILL_W'(1);
          end
        end
      end
      if (cmd_i.ema) begin
        if (cand_held_q) peak_mean_q <= ema_f(peak_mean_q, cand_amp_q);
        prev_motion_q <= mot_now_q;
        last_x_q      <= x_q;
        prev_slope_q  <= slope;
        have_prev_q   <= 1'b1;
      end
      if (cmd_i.thr) begin
        if (q_thr < FLOOR_EXT) begin
          thr_q <= SB'(THRESH_FLOOR);
        end else if (q_thr > MAX_EXT) begin
          thr_q <= MAX_POS;
        end else begin
          thr_q <= SB'(q_thr);
        end
      end
      if (cmd_i.med_step) begin
        med_i_q <= med_i_q + PTR_W'(1);
      end
      if (cmd_i.med_fin) begin
        if (fill_q < FILL_W'(MEDIAN_MIN_COUNT)) begin
          med2_q <= '0;
        end else if (fill_q[0]) begin
          med2_q <= {hi_q, 1'b0};
        end else begin
          med2_q <= {1'b0, lo_q} + {1'b0, hi_q};
        end
      end
      if (cmd_i.miss) begin
        cnt_q <= cnt_q + IDX_W'(1);
        if (miss_hit) begin
          last_q <= miss_at;
          nres_q <= nres_q + 2'd1;
        end
      end
      if (push) wr_q <= wr_q + FIFO_PTR_W'(1);
      if (pop)  rd_q <= rd_q + FIFO_PTR_W'(1);
      if (push && !pop) begin
        fcnt_q <= fcnt_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fcnt_q <= fcnt_q - FIFO_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/ppg_adaptive_peak_detector.sv
// Top level of the PPG adaptive peak detector.
// Takes one PPG sample per transaction and reports confirmed systolic peaks and interpolated
// missed beats, up to two results per sample, through a four-entry result queue. A sample
// steps through the candidate, confirmation, EMA and threshold states; when a new interval
// enters the ring, a median rank scan follows that visits one ring entry per cycle, then
// the missed-beat check and one push per queued result. A new sample is accepted only
// after the last one is finished and while the queue has room for two results.
`default_nettype none
module ppg_adaptive_peak_detector #(
  parameter int HISTORY_DEPTH = 8,
  parameter int SAMPLE_BITS   = 16,
  parameter int INTERVAL_BITS = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  wire logic [ppgpd_pkg::MOT_W-1:0]       motion_i,
  input  wire logic                              motion_present_i,
  input  wire logic                              buffer_end_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ppgpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ppgpd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ppgpd_pkg::IDX_W-1:0]            peak_index_o,
  output logic signed [SAMPLE_BITS-1:0]          amplitude_o,
  output logic [ppgpd_pkg::IV_W-1:0]             interval_o,
  output logic                                   flag_outlier_o,
  output logic                                   flag_motion_o,
  output logic                                   flag_interpolated_o,
  output logic [ppgpd_pkg::IV_W-1:0]             median_interval_o,
  output logic                                   last_of_run_o
);
  import ppgpd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ppgpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppgpd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .sample_i            (sample_i),
    .motion_i            (motion_i),
    .motion_present_i    (motion_present_i),
    .buffer_end_i        (buffer_end_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .peak_index_o        (peak_index_o),
    .amplitude_o         (amplitude_o),
    .interval_o          (interval_o),
    .flag_outlier_o      (flag_outlier_o),
    .flag_motion_o       (flag_motion_o),
    .flag_interpolated_o (flag_interpolated_o),
    .median_interval_o   (median_interval_o),
    .last_of_run_o       (last_of_run_o)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the PPG adaptive peak detector with a scoreboard class.
`default_nettype none

module tb;
  import ppgpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [31:0]        peak_index;
    bit signed [15:0] amplitude;
    bit [11:0]        interval;
    bit               outlier;
    bit               motion;
    bit               interpolated;
    bit [11:0]        median;
    bit               last;
  } beat_t;

  class beat_scoreboard;
    int unsigned thr_factor, min_iv, max_iv, out_low, out_high, mot_limit;
    int          last_x, prev_slope;
    int unsigned prev_motion;
    bit          have_prev;
    int          cand_amp;
    int unsigned cand_at, cand_motion;
    bit          cand_held;
    int unsigned last_peak_at;
    bit          has_prior_beat;
    int          peak_mean, trough_mean, threshold;
    int unsigned iv_ring[8];
    int unsigned ring_pos, ring_fill, samples_seen;
    beat_t       expected_beats[$];
    int          errors;

    function void reset_state();
      thr_factor = THR_FACTOR_RESET;
      min_iv = MIN_IV_RESET;
      max_iv = MAX_IV_RESET;
      out_low = OUT_LOW_RESET;
      out_high = OUT_HIGH_RESET;
      mot_limit = MOT_LIMIT_RESET;
      last_x = 0;
      prev_slope = 0;
      prev_motion = 0;
      have_prev = 0;
      cand_amp = 0;
      cand_at = 0;
      cand_motion = 0;
      cand_held = 0;
      last_peak_at = 0;
      has_prior_beat = 0;
      peak_mean = 8192;
      trough_mean = 0;
      threshold = (thr_factor * 8192) >> 8;
      ring_pos = 0;
      ring_fill = 0;
      samples_seen = 0;
      errors = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THR_FACTOR: thr_factor = data[7:0];
        REG_MIN_IV: min_iv = data[11:0];
        REG_MAX_IV: max_iv = data[11:0];
        REG_OUT_LOW: out_low = data[7:0];
        REG_OUT_HIGH: out_high = data[7:0];
        REG_MOTION_LIMIT: mot_limit = data;
        default: ;
      endcase
    endfunction

    function int unsigned twice_median();
      int unsigned t[$];
      if (ring_fill < MEDIAN_MIN_COUNT) return 0;
      for (int i = 0; i < ring_fill; i++) t.push_back(iv_ring[i]);
      t.sort();
      if (ring_fill % 2) return 2 * t[ring_fill / 2];
      return t[ring_fill / 2 - 1] + t[ring_fill / 2];
    endfunction

    function int ema_step(int m, int x);
      return m + ((x - m) >>> EMA_SHIFT);
    endfunction

    function void note_sample(int x, int unsigned mot_in, bit present, bit bend);
      int unsigned mot_now, here, iv, md, elapsed, med, m2;
      int          slope;
      bit          close, emit, outl;
      longint      p, q;
      beat_t       b, run[$];
      mot_now = present ? mot_in : prev_motion;
      here = samples_seen;
      slope = have_prev ? x - last_x : 0;
      if (have_prev && prev_slope > 0 && slope <= 0) begin
        if (last_x > threshold) begin
          close = has_prior_beat && (here - 32'd1 - last_peak_at < min_iv);
          if (!close && (!cand_held || last_x > cand_amp)) begin
            cand_amp = last_x;
            cand_at = here - 32'd1;
            cand_motion = prev_motion;
            cand_held = 1;
          end
        end else begin
          trough_mean = ema_step(trough_mean, last_x);
        end
      end
      if (cand_held && x < trough_mean && slope < 0) begin
        iv = 0;
        outl = 0;
        emit = 1;
        if (has_prior_beat) begin
          iv = cand_at - last_peak_at;
          if (iv < min_iv || iv > max_iv) begin
            last_peak_at = cand_at;
            cand_held = 0;
            emit = 0;
          end else begin
            md = twice_median();
            if (md >= 2 && (longint'(iv) * 128 > longint'(md) * out_high ||
                            longint'(iv) * 128 < longint'(md) * out_low)) outl = 1;
          end
        end
        if (emit) begin
          b.peak_index = cand_at;
          b.amplitude = cand_amp;
          b.interval = iv;
          b.outlier = outl;
          b.motion = cand_motion > mot_limit;
          b.interpolated = 0;
          run.push_back(b);
          if (iv > 0) begin
            iv_ring[ring_pos] = iv & 12'hFFF;
            ring_pos = (ring_pos + 1) % 8;
            if (ring_fill < 8) ring_fill++;
          end
          last_peak_at = cand_at;
          has_prior_beat = 1;
          cand_held = 0;
        end
      end
      if (cand_held) peak_mean = ema_step(peak_mean, cand_amp);
      p = longint'(thr_factor) * (peak_mean - trough_mean);
      q = p >>> 8;
      if (q < THRESH_FLOOR) q = THRESH_FLOOR;
      if (q > 32767) q = 32767;
      threshold = q;
      prev_motion = mot_now;
      last_x = x;
      prev_slope = slope;
      have_prev = 1;
      if (bend && has_prior_beat) begin
        md = twice_median();
        if (md >= 2) begin
          elapsed = here + 32'd1 - last_peak_at;
          med = md >> 1;
          if (longint'(elapsed) * 128 > longint'(md) * out_high && med < elapsed) begin
            b.peak_index = last_peak_at + med;
            b.amplitude = 0;
            b.interval = med;
            b.outlier = 0;
            b.motion = 0;
            b.interpolated = 1;
            run.push_back(b);
            last_peak_at = last_peak_at + med;
          end
        end
      end
      samples_seen = here + 32'd1;
      m2 = twice_median();
      foreach (run[k]) begin
        run[k].median = (m2 >> 1) & 12'hFFF;
        run[k].last = (k == run.size() - 1);
        expected_beats.push_back(run[k]);
      end
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(beat_t got);
      beat_t e;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual index %0d", $time,
                 got.peak_index);
        errors++;
        return;
      end
      e = expected_beats.pop_front();
      compare_field("peak_index", e.peak_index, got.peak_index);
      compare_field("amplitude", e.amplitude, got.amplitude);
      compare_field("interval", e.interval, got.interval);
      compare_field("flag_outlier", e.outlier, got.outlier);
      compare_field("flag_motion", e.motion, got.motion);
      compare_field("flag_interpolated", e.interpolated, got.interpolated);
      compare_field("median_interval", e.median, got.median);
      compare_field("last_of_run", e.last, got.last);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic signed [15:0]    sample_i = '0;
  logic [MOT_W-1:0]      motion_i = '0;
  logic                  motion_present_i = 1'b0;
  logic                  buffer_end_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [IDX_W-1:0]      peak_index_o;
  logic signed [15:0]    amplitude_o;
  logic [IV_W-1:0]       interval_o;
  logic                  flag_outlier_o, flag_motion_o, flag_interpolated_o;
  logic [IV_W-1:0]       median_interval_o;
  logic                  last_of_run_o;

  beat_scoreboard sb;
  bit             gaps_on = 1'b1;
  int             quiet_cycles = 0;

  ppg_adaptive_peak_detector i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) out_ready_i <= !gaps_on || $urandom_range(99) >= 34;

  always @(posedge clk_i) begin
    beat_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.peak_index = peak_index_o;
      got.amplitude = amplitude_o;
      got.interval = interval_o;
      got.outlier = flag_outlier_o;
      got.motion = flag_motion_o;
      got.interpolated = flag_interpolated_o;
      got.median = median_interval_o;
      got.last = last_of_run_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input int x, input int unsigned mot, input bit present,
                             input bit bend);
    while (gaps_on && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    sample_i <= x;
    motion_i <= mot;
    motion_present_i <= present;
    buffer_end_i <= bend;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(x, mot & 16'hFFFF, present, bend);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic run_beats(input int count);
    int left, period, rise, amp, low, level, k;
    bit skip;
    left = count;
    while (left > 0) begin
      period = ($urandom_range(3) == 0) ? $urandom_range(4, 40) : $urandom_range(30, 160);
      rise = $urandom_range(1, period / 3 + 1);
      amp = $urandom_range(2000, 32767);
      low = -int'($urandom_range(1000, 32768));
      skip = $urandom_range(9) == 0;
      for (k = 0; k < period && left > 0; k++) begin
        if ($urandom_range(19) == 0) level = int'($urandom_range(65535)) - 32768;
        else if (skip) level = low;
        else if (k < rise) level = low + (amp - low) * k / rise;
        else level = amp - (amp - low) * (k - rise) / (period - rise);
        level += int'($urandom_range(200)) - 100;
        send_sample(level, ($urandom_range(3) == 0) ? $urandom_range(8000) :
                    $urandom_range(65535), $urandom_range(99) < 70,
                    $urandom_range(29) == 0);
        left--;
      end
    end
  endtask

  initial begin
    int unsigned phase_regs[6][6] = '{
      '{102, 30, 200, 32, 96, 4915},
      '{255, 1, 4095, 0, 255, 0},
      '{0, 4095, 4095, 255, 0, 65535},
      '{60, 10, 150, 40, 80, 20000},
      '{200, 20, 120, 50, 100, 8000},
      '{128, 5, 400, 16, 160, 3000}};
    sb = new;
    sb.reset_state();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        in_valid_i <= 1'b0;
        while (sb.expected_beats.size() != 0) @(negedge clk_i);
        repeat (40) @(negedge clk_i);
      end
      write_cfg(REG_THR_FACTOR, phase_regs[ph][0]);
      write_cfg(REG_MIN_IV, phase_regs[ph][1]);
      write_cfg(REG_MAX_IV, phase_regs[ph][2]);
      write_cfg(REG_OUT_LOW, phase_regs[ph][3]);
      write_cfg(REG_OUT_HIGH, phase_regs[ph][4]);
      write_cfg(REG_MOTION_LIMIT, phase_regs[ph][5]);
      if (ph == 3) begin
        write_cfg(3'd6, $urandom_range(65535));
        write_cfg(3'd7, 16'hFFFF);
      end
      cfg_valid_i <= 1'b0;
      gaps_on = (ph != 3);
      if (ph == 0) begin
        send_sample(0, 0, 1, 0);
        send_sample(16000, 65535, 1, 0);
        send_sample(32767, 65535, 1, 0);
        send_sample(32767, 0, 0, 0);
        send_sample(-32768, 0, 1, 0);
        send_sample(-32768, 0, 1, 1);
        for (int i = 0; i < 40; i += 2) begin
          send_sample(-20000 + i * 1000, 100, 0, 0);
        end
        send_sample(30000, 0, 1, 0);
        send_sample(-32768, 0, 1, 0);
        for (int i = 0; i < 10; i++) send_sample(-30000 + i * 100, 0, 0, i == 9);
      end
      run_beats(300);
    end
    in_valid_i <= 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
